// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition on the next edge follows from one on this edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/daratp_pkg.sv =====
// ----------------------------------------------------------------------------
// daratp_pkg
// Types and constants of the address-range table parser.
// ----------------------------------------------------------------------------
package daratp_pkg;
	localparam int MaxAddressBytes = 8;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_ENTRY  = 2'd1;
	localparam logic [1:0] KIND_STOP   = 2'd2;

	localparam logic CFG_SECTION_BYTES = 1'b0;
	localparam logic CFG_BYTE_ORDER    = 1'b1;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [63:0] set_length;
		logic        wide_offsets;
		logic [15:0] format_version;
		logic [63:0] info_offset;
		logic [3:0]  address_bytes;
		logic [7:0]  segment_bytes;
		logic [63:0] range_start;
		logic [63:0] range_length;
		logic        last_of_set;
	} record_t;
endpackage

// ===== hdl/daratp_byte_if.sv =====
// ----------------------------------------------------------------------------
// daratp_byte_if
// Valid/ready channel carrying one section byte.
// ----------------------------------------------------------------------------
interface daratp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] section_byte;
	modport source (output valid, output section_byte, input ready);
	modport sink (input valid, input section_byte, output ready);
endinterface

// ===== hdl/daratp_record_if.sv =====
// ----------------------------------------------------------------------------
// daratp_record_if
// Valid/ready channel carrying one parsed record.
// ----------------------------------------------------------------------------
interface daratp_record_if;
	logic        valid;
	logic        ready;
	logic [1:0]  record_kind;
	logic [63:0] set_length;
	logic        wide_offsets;
	logic [15:0] format_version;
	logic [63:0] info_offset;
	logic [3:0]  address_bytes;
	logic [7:0]  segment_bytes;
	logic [63:0] range_start;
	logic [63:0] range_length;
	logic        last_of_set;
	modport source (output valid, output record_kind, output set_length,
		output wide_offsets, output format_version, output info_offset,
		output address_bytes, output segment_bytes, output range_start,
		output range_length, output last_of_set, input ready);
	modport sink (input valid, input record_kind, input set_length,
		input wide_offsets, input format_version, input info_offset,
		input address_bytes, input segment_bytes, input range_start,
		input range_length, input last_of_set, output ready);
endinterface

// ===== hdl/daratp_out_buf.sv =====
// ----------------------------------------------------------------------------
// daratp_out_buf
// Two-entry skid buffer for result records.
// ----------------------------------------------------------------------------
module daratp_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  daratp_pkg::record_t in_rec,
	output logic                out_valid,
	input  logic                out_ready,
	output daratp_pkg::record_t out_rec
);
	import daratp_pkg::*;

	record_t main_q, skid_q;
	logic    main_vld_q, skid_vld_q;

	assign in_ready  = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_rec   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!main_vld_q || out_ready) begin
				if (skid_vld_q) begin
					main_vld_q <= 1'b1;
					skid_vld_q <= in_valid;
				end else begin
					main_vld_q <= in_valid;
				end
			end else if (in_valid) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || out_ready) begin
			main_q <= skid_vld_q ? skid_q : in_rec;
			if (skid_vld_q) skid_q <= in_rec;
		end else if (in_valid && !skid_vld_q) begin
			skid_q <= in_rec;
		end
	end
endmodule

// ===== hdl/dwarf_address_range_table_parser.sv =====
// ----------------------------------------------------------------------------
// dwarf_address_range_table_parser
// Walks an address-range section one byte per transaction.
// ----------------------------------------------------------------------------
// Output: a record is registered when the byte completing it is taken.
// Throughput: one byte per cycle unless the output buffer is full; the
//   parse state updates per byte; a two-entry buffer absorbs output stalls.
// Reset: arst_n clears the parse state and configuration to zero; the
//   parser then expects an initial length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwarf_address_range_table_parser #(
	parameter int MAX_ADDRESS_BYTES = daratp_pkg::MaxAddressBytes
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	daratp_byte_if.sink     in_ch,
	daratp_record_if.source out_ch
);
	import daratp_pkg::*;

	localparam logic [3:0] PH_LEN32   = 4'd0;
	localparam logic [3:0] PH_LEN64   = 4'd1;
	localparam logic [3:0] PH_VERSION = 4'd2;
	localparam logic [3:0] PH_OFFSET  = 4'd3;
	localparam logic [3:0] PH_ASIZE   = 4'd4;
	localparam logic [3:0] PH_SSIZE   = 4'd5;
	localparam logic [3:0] PH_PAD     = 4'd6;
	localparam logic [3:0] PH_START   = 4'd7;
	localparam logic [3:0] PH_LENGTH  = 4'd8;
	localparam logic [3:0] PH_SKIP    = 4'd9;

	// Configuration registers.
	logic [31:0] section_bytes_q;
	logic        big_q;

	// Parse state.
	logic [3:0]  phase_q;
	logic [31:0] pos_q;
	logic [63:0] left_q;
	logic [63:0] acc_q;
	logic [3:0]  cnt_q;
	logic        wide_q;
	logic [15:0] ver_q;
	logic [63:0] ioff_q;
	logic [7:0]  asz_q;
	logic [63:0] ents_q;
	logic [63:0] rstart_q;
	logic        stopped_q;

	// Next-state values.
	logic [3:0]  phase_d;
	logic [31:0] pos_d;
	logic [63:0] left_d;
	logic [63:0] acc_d;
	logic [3:0]  cnt_d;
	logic        wide_d;
	logic [15:0] ver_d;
	logic [63:0] ioff_d;
	logic [7:0]  asz_d;
	logic [63:0] ents_d;
	logic [63:0] rstart_d;
	logic        stopped_d;

	logic        emit;
	record_t     rec;
	logic        buf_ready;
	logic        fire;
	record_t     out_rec;

	// Byte merged into the accumulator in the configured order.
	logic [63:0] acc_take;
	logic [3:0]  cnt_take;
	logic [3:0]  need_len;
	logic [63:0] avail;
	logic [63:0] hdr_size;
	logic        asz_ok;
	logic [63:0] pad;
	logic [63:0] rem_pad;
	logic [63:0] count;
	logic [3:0]  asz_lo;
	logic [63:0] ents_dec;
	logic        is_last;

	assign in_ch.ready = buf_ready;
	assign fire = in_ch.valid && buf_ready;

	always_comb begin
		if (big_q) acc_take = {acc_q[55:0], in_ch.section_byte};
		else acc_take = acc_q | ({56'd0, in_ch.section_byte} << {cnt_q[2:0], 3'b000});
		cnt_take = cnt_q + 4'd1;
	end

	// The pad is (2a - off mod 2a) mod 2a for off of 12 or 24; the count
	// divides by a power of two, so both reduce to shifts and small constants.
	always_comb begin
		asz_ok = (asz_q == 8'd1 || asz_q == 8'd2 || asz_q == 8'd4 || asz_q == 8'd8)
			&& ({24'd0, asz_q} <= 32'(MAX_ADDRESS_BYTES));
		pad = 64'd0;
		case (asz_q)
			8'd1: pad = 64'd0;
			8'd2: pad = 64'd0;
			8'd4: pad = wide_q ? 64'd0 : 64'd4;
			8'd8: pad = wide_q ? 64'd8 : 64'd4;
			default: pad = 64'd0;
		endcase
		rem_pad = left_q - 64'd1 - pad;
		count = 64'd0;
		case (asz_q)
			8'd1: count = rem_pad >> 1;
			8'd2: count = rem_pad >> 2;
			8'd4: count = rem_pad >> 3;
			8'd8: count = rem_pad >> 4;
			default: count = 64'd0;
		endcase
		asz_lo = asz_q[3:0];
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		left_d    = left_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		wide_d    = wide_q;
		ver_d     = ver_q;
		ioff_d    = ioff_q;
		asz_d     = asz_q;
		ents_d    = ents_q;
		rstart_d  = rstart_q;
		stopped_d = stopped_q;
		emit      = 1'b0;
		rec       = '0;
		need_len  = (phase_q == PH_LEN32) ? 4'd4 : 4'd8;
		avail     = {32'd0, section_bytes_q - pos_q - 32'd1};
		hdr_size  = wide_q ? 64'd12 : 64'd8;
		ents_dec  = (ents_q != 64'd0) ? ents_q - 64'd1 : 64'd0;
		is_last   = 1'b0;

		if (!stopped_q) begin
			if (phase_q == PH_LEN32 || phase_q == PH_LEN64) begin
				if (pos_q >= section_bytes_q) begin
					// Outside the section: silent at a unit boundary, else stop.
					if (!(phase_q == PH_LEN32 && cnt_q == 4'd0)) begin
						emit = 1'b1;
					end
				end else begin
					pos_d = pos_q + 32'd1;
					if (cnt_take < need_len) begin
						acc_d = acc_take;
						cnt_d = cnt_take;
						if (pos_q + 32'd1 >= section_bytes_q) emit = 1'b1;
					end else begin
						acc_d = '0;
						cnt_d = '0;
						if (phase_q == PH_LEN32 && acc_take == 64'h0000_0000_FFFF_FFFF) begin
							phase_d = PH_LEN64;
							wide_d  = 1'b1;
							if (pos_q + 32'd1 >= section_bytes_q) emit = 1'b1;
						end else begin
							if (phase_q == PH_LEN32) wide_d = 1'b0;
							if (acc_take < ((phase_q == PH_LEN64) ? 64'd12 : 64'd8)
								|| acc_take > avail) begin
								emit = 1'b1;
							end else begin
								left_d  = acc_take;
								phase_d = PH_VERSION;
							end
						end
					end
				end
				if (emit) begin
					// Stop transaction: clear the field, hold stopped.
					acc_d     = '0;
					cnt_d     = '0;
					stopped_d = 1'b1;
					rec.record_kind = KIND_STOP;
				end
			end else begin
				if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;
				if (left_q != 64'd0) left_d = left_q - 64'd1;
				unique case (phase_q)
					PH_VERSION: begin
						if (cnt_take >= 4'd2) begin
							ver_d   = acc_take[15:0];
							acc_d   = '0;
							cnt_d   = '0;
							phase_d = PH_OFFSET;
						end else begin
							acc_d = acc_take;
							cnt_d = cnt_take;
						end
					end
					PH_OFFSET: begin
						if (cnt_take >= (wide_q ? 4'd8 : 4'd4)) begin
							ioff_d  = acc_take;
							acc_d   = '0;
							cnt_d   = '0;
							phase_d = PH_ASIZE;
						end else begin
							acc_d = acc_take;
							cnt_d = cnt_take;
						end
					end
					PH_ASIZE: begin
						asz_d   = in_ch.section_byte;
						phase_d = PH_SSIZE;
					end
					PH_SSIZE: begin
						emit = 1'b1;
						if (!asz_ok || pad > left_d || count == 64'd0) begin
							acc_d     = '0;
							cnt_d     = '0;
							stopped_d = 1'b1;
							rec.record_kind = KIND_STOP;
						end else begin
							ents_d = count;
							rec.record_kind    = KIND_HEADER;
							rec.set_length     = left_d + hdr_size;
							rec.wide_offsets   = wide_q;
							rec.format_version = ver_q;
							rec.info_offset    = ioff_q;
							rec.address_bytes  = asz_lo;
							rec.segment_bytes  = in_ch.section_byte;
							acc_d = '0;
							if (pad != 64'd0) begin
								cnt_d   = pad[3:0];
								phase_d = PH_PAD;
							end else begin
								cnt_d   = '0;
								phase_d = PH_START;
							end
						end
					end
					PH_PAD: begin
						if (cnt_q <= 4'd1) begin
							acc_d   = '0;
							cnt_d   = '0;
							phase_d = PH_START;
						end else begin
							cnt_d = cnt_q - 4'd1;
						end
					end
					PH_START: begin
						if ({4'd0, cnt_take} >= asz_q) begin
							rstart_d = acc_take;
							acc_d    = '0;
							cnt_d    = '0;
							phase_d  = PH_LENGTH;
						end else begin
							acc_d = acc_take;
							cnt_d = cnt_take;
						end
					end
					PH_LENGTH: begin
						if ({4'd0, cnt_take} >= asz_q) begin
							acc_d   = '0;
							cnt_d   = '0;
							ents_d  = ents_dec;
							is_last = (rstart_q == 64'd0 && acc_take == 64'd0)
								|| ents_dec == 64'd0;
							emit    = 1'b1;
							rec.record_kind  = KIND_ENTRY;
							rec.range_start  = rstart_q;
							rec.range_length = acc_take;
							rec.last_of_set  = is_last;
							if (is_last) phase_d = (left_d != 64'd0) ? PH_SKIP : PH_LEN32;
							else phase_d = PH_START;
						end else begin
							acc_d = acc_take;
							cnt_d = cnt_take;
						end
					end
					PH_SKIP: begin
						if (left_d == 64'd0) begin
							acc_d   = '0;
							cnt_d   = '0;
							phase_d = PH_LEN32;
						end
					end
					default: begin
						acc_d   = '0;
						cnt_d   = '0;
						phase_d = PH_LEN32;
					end
				endcase
			end
		end
	end

	// Configuration writes; an unknown index does nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_bytes_q <= '0;
			big_q           <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SECTION_BYTES: section_bytes_q <= cfg_data;
				CFG_BYTE_ORDER:    big_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the parse state on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN32;
			pos_q     <= '0;
			left_q    <= '0;
			acc_q     <= '0;
			cnt_q     <= '0;
			wide_q    <= 1'b0;
			ver_q     <= '0;
			ioff_q    <= '0;
			asz_q     <= '0;
			ents_q    <= '0;
			rstart_q  <= '0;
			stopped_q <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			left_q    <= left_d;
			acc_q     <= acc_d;
			cnt_q     <= cnt_d;
			wide_q    <= wide_d;
			ver_q     <= ver_d;
			ioff_q    <= ioff_d;
			asz_q     <= asz_d;
			ents_q    <= ents_d;
			rstart_q  <= rstart_d;
			stopped_q <= stopped_d;
		end
	end

	daratp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fire && emit),
		.in_ready  (buf_ready),
		.in_rec    (rec),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_rec   (out_rec)
	);

	assign out_ch.record_kind    = out_rec.record_kind;
	assign out_ch.set_length     = out_rec.set_length;
	assign out_ch.wide_offsets   = out_rec.wide_offsets;
	assign out_ch.format_version = out_rec.format_version;
	assign out_ch.info_offset    = out_rec.info_offset;
	assign out_ch.address_bytes  = out_rec.address_bytes;
	assign out_ch.segment_bytes  = out_rec.segment_bytes;
	assign out_ch.range_start    = out_rec.range_start;
	assign out_ch.range_length   = out_rec.range_length;
	assign out_ch.last_of_set    = out_rec.last_of_set;

	// Once stopped, the parser never leaves the stopped state.
	`ASSERT_NEXT(a_stop_sticks, clk, arst_n, stopped_q, stopped_q, "stop state left")
	// A stopped parser emits nothing.
	`ASSERT_IMPLY(a_no_emit_stopped, clk, arst_n, stopped_q, !emit, "emit after stop")
	// Emitting a stop record must set the stop state.
	`ASSERT_NEXT(a_stop_sets, clk, arst_n, fire && emit && rec.record_kind == KIND_STOP,
		stopped_q, "stop record without stop state")
endmodule

// ===== tb/tb_dwarf_address_range_table_parser.sv =====
// ----------------------------------------------------------------------------
// tb_dwarf_address_range_table_parser
// Streams address-range sections into the parser and checks every record.
// A behavioral copy of the parser predicts each record from the accepted
// bytes. Sections are built from well-formed units with random content, and
// the run closes on one malformed unit that stops the parser for good.
// ----------------------------------------------------------------------------
module tb_dwarf_address_range_table_parser;
	import daratp_pkg::*;

	localparam int STALL_LIMIT = 10000;
	localparam int TARGET_BYTES = 1250;

	typedef enum logic [3:0] {
		P_LEN32, P_LEN64, P_VERSION, P_OFFSET, P_ASIZE,
		P_SSIZE, P_PAD, P_START, P_LENGTH, P_SKIP
	} phase_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	daratp_byte_if byte_ch ();
	daratp_record_if rec_ch ();

	dwarf_address_range_table_parser DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(byte_ch), .out_ch(rec_ch)
	);

	always #1 clk = ~clk;

	// Parser copy: configuration and walk state.
	logic [31:0] sec_size;
	logic        sec_big;
	phase_e      ph;
	logic [31:0] sec_pos;
	logic [63:0] unit_left;
	logic [63:0] acc;
	logic [3:0]  acc_cnt;
	logic        unit_wide;
	logic [15:0] hold_version;
	logic [63:0] hold_offset;
	logic [7:0]  hold_asize;
	logic [7:0]  hold_ssize;
	logic [63:0] pairs_left;
	logic [63:0] hold_start;
	logic        halted;

	record_t     expected_records[$];
	logic [7:0]  pending_bytes[$];
	logic [7:0]  unit_bytes[$];
	logic        build_big;
	int          mismatches = 0;
	int          cycle = 0;
	int          stall_cycles = 0;
	int          sent = 0;

	function automatic void take_byte(input logic [7:0] b);
		if (sec_big)
			acc = (acc << 8) | 64'(b);
		else
			acc |= 64'(b) << (8 * acc_cnt[2:0]);
		acc_cnt = acc_cnt + 4'd1;
	endfunction

	function automatic void halt_parse();
		record_t r;
		r = '0;
		r.record_kind = KIND_STOP;
		acc = '0;
		acc_cnt = '0;
		halted = 1'b1;
		expected_records.push_back(r);
	endfunction

	// Advance the parser copy by one accepted byte.
	function automatic void parse_byte(input logic [7:0] b);
		int unsigned need;
		logic [63:0] v, rest, pair, pad, cnt, len;
		record_t r;
		if (halted)
			return;
		if (ph == P_LEN32 || ph == P_LEN64) begin
			need = (ph == P_LEN32) ? 4 : 8;
			if (sec_pos >= sec_size) begin
				if (!(ph == P_LEN32 && acc_cnt == 0))
					halt_parse();
				return;
			end
			sec_pos++;
			take_byte(b);
			if (acc_cnt < need) begin
				if (sec_pos >= sec_size)
					halt_parse();
				return;
			end
			v = acc;
			acc = '0;
			acc_cnt = '0;
			if (ph == P_LEN32 && v == 64'hFFFF_FFFF) begin
				ph = P_LEN64;
				unit_wide = 1'b1;
				if (sec_pos >= sec_size)
					halt_parse();
				return;
			end
			if (ph == P_LEN32)
				unit_wide = 1'b0;
			rest = unit_wide ? 12 : 8;
			if (v < rest || v > 64'(sec_size - sec_pos)) begin
				halt_parse();
			end else begin
				unit_left = v;
				ph = P_VERSION;
			end
			return;
		end
		if (sec_pos != 32'hFFFF_FFFF)
			sec_pos++;
		if (unit_left != 0)
			unit_left--;
		case (ph)
			P_VERSION: begin
				take_byte(b);
				if (acc_cnt >= 2) begin
					hold_version = acc[15:0];
					acc = '0;
					acc_cnt = '0;
					ph = P_OFFSET;
				end
			end
			P_OFFSET: begin
				take_byte(b);
				if (acc_cnt >= (unit_wide ? 8 : 4)) begin
					hold_offset = acc;
					acc = '0;
					acc_cnt = '0;
					ph = P_ASIZE;
				end
			end
			P_ASIZE: begin
				hold_asize = b;
				ph = P_SSIZE;
			end
			P_SSIZE: begin
				hold_ssize = b;
				if (!(hold_asize inside {8'd1, 8'd2, 8'd4, 8'd8})
						|| hold_asize > MaxAddressBytes) begin
					halt_parse();
					return;
				end
				pair = 2 * 64'(hold_asize);
				pad = (pair - (unit_wide ? 64'd24 : 64'd12) % pair) % pair;
				if (pad > unit_left) begin
					halt_parse();
					return;
				end
				cnt = (unit_left - pad) / pair;
				if (cnt == 0) begin
					halt_parse();
					return;
				end
				pairs_left = cnt;
				r = '0;
				r.record_kind = KIND_HEADER;
				r.set_length = unit_left + (unit_wide ? 64'd12 : 64'd8);
				r.wide_offsets = unit_wide;
				r.format_version = hold_version;
				r.info_offset = hold_offset;
				r.address_bytes = hold_asize[3:0];
				r.segment_bytes = hold_ssize;
				expected_records.push_back(r);
				acc = '0;
				acc_cnt = '0;
				if (pad != 0) begin
					acc_cnt = pad[3:0];
					ph = P_PAD;
				end else begin
					ph = P_START;
				end
			end
			P_PAD: begin
				if (acc_cnt != 0)
					acc_cnt--;
				if (acc_cnt == 0) begin
					acc = '0;
					ph = P_START;
				end
			end
			P_START: begin
				take_byte(b);
				if (acc_cnt >= hold_asize) begin
					hold_start = acc;
					acc = '0;
					acc_cnt = '0;
					ph = P_LENGTH;
				end
			end
			P_LENGTH: begin
				take_byte(b);
				if (acc_cnt < hold_asize)
					return;
				len = acc;
				acc = '0;
				acc_cnt = '0;
				if (pairs_left != 0)
					pairs_left--;
				r = '0;
				r.record_kind = KIND_ENTRY;
				r.range_start = hold_start;
				r.range_length = len;
				r.last_of_set = (hold_start == 0 && len == 0) || pairs_left == 0;
				expected_records.push_back(r);
				if (r.last_of_set)
					ph = (unit_left != 0) ? P_SKIP : P_LEN32;
				else
					ph = P_START;
			end
			P_SKIP: begin
				if (unit_left == 0) begin
					acc = '0;
					acc_cnt = '0;
					ph = P_LEN32;
				end
			end
			default: begin
				acc = '0;
				acc_cnt = '0;
				ph = P_LEN32;
			end
		endcase
	endfunction

	// Append a multi-byte field in the byte order of the section being built.
	function automatic void add_field(input logic [63:0] v, input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = build_big ? n - 1 - i : i;
			unit_bytes.push_back(v[8*k +: 8]);
		end
	endfunction

	function automatic logic [63:0] rand_value(input int n);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (n < 8)
			v &= (64'd1 << (8 * n)) - 1;
		return v;
	endfunction

	// Build one well-formed unit: slots pairs fit the unit, used of them are
	// written (the last one a zero pair when zero_end), tail bytes follow.
	function automatic void add_unit(input bit wide, input int asz, input int slots,
			input int used, input bit zero_end, input int tail,
			input logic [15:0] ver, input logic [63:0] off);
		int pair, pad, hdr;
		logic [63:0] s, l;
		pair = 2 * asz;
		pad = (pair - (wide ? 24 : 12) % pair) % pair;
		hdr = wide ? 12 : 8;
		if (wide) begin
			add_field(64'hFFFF_FFFF, 4);
			add_field(64'(hdr + pad + slots * pair + tail), 8);
		end else begin
			add_field(64'(hdr + pad + slots * pair + tail), 4);
		end
		add_field(64'(ver), 2);
		if (wide)
			add_field(off, 8);
		else
			add_field(off & 64'hFFFF_FFFF, 4);
		unit_bytes.push_back(8'(asz));
		unit_bytes.push_back(8'($urandom));
		repeat (pad) unit_bytes.push_back(8'($urandom));
		for (int i = 0; i < used; i++) begin
			if (zero_end && i == used - 1) begin
				s = 0;
				l = 0;
			end else begin
				do begin
					s = rand_value(asz);
					l = rand_value(asz);
				end while (s == 0 && l == 0);
			end
			add_field(s, asz);
			add_field(l, asz);
		end
		repeat ((slots - used) * pair + tail) unit_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_random_unit();
		int asz, slots, used;
		bit zend;
		asz = 1 << $urandom_range(0, 3);
		slots = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
		zend = $urandom_range(0, 1);
		used = zend ? $urandom_range(1, slots) : slots;
		add_unit($urandom_range(0, 3) == 0, asz, slots, used, zend,
			$urandom_range(0, 2) == 0 ? $urandom_range(0, 2 * asz - 1) : 0,
			16'($urandom), {$urandom, $urandom});
	endfunction

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_SECTION_BYTES)
			sec_size = val;
		else
			sec_big = val[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every byte is taken and every record is back, then let the
	// pipeline drain before touching configuration.
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || byte_ch.valid || expected_records.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Flush the built units as one section sized to end exactly after them,
	// or at the largest size when max_size, else optionally trailed by outside bytes.
	task automatic send_section(input bit big, input bit max_size, input int noise);
		write_reg(CFG_BYTE_ORDER, 32'(big));
		write_reg(CFG_SECTION_BYTES, max_size ? 32'hFFFF_FFFF
			: sec_pos + 32'(unit_bytes.size()));
		sent += unit_bytes.size();
		while (unit_bytes.size() != 0)
			pending_bytes.push_back(unit_bytes.pop_front());
		if (!max_size)
			repeat (noise) pending_bytes.push_back(8'($urandom));
		wait_idle();
	endtask

	// Driver: advance the byte queue on each transaction, hold an offered
	// byte until it is taken, idle at random except in a long quiet window.
	always @(posedge clk) begin
		logic took;
		took = byte_ch.valid && byte_ch.ready;
		if (took) begin
			parse_byte(byte_ch.section_byte);
			void'(pending_bytes.pop_front());
		end
		cycle <= cycle + 1;
		if (byte_ch.valid && !took) begin
			byte_ch.valid <= 1'b1;
		end else if (pending_bytes.size() != 0 && (cycle inside {[400:1000]}
				|| $urandom_range(0, 99) >= 8)) begin
			byte_ch.valid <= 1'b1;
			byte_ch.section_byte <= pending_bytes[0];
		end else begin
			byte_ch.valid <= 1'b0;
			byte_ch.section_byte <= 8'($urandom);
		end
	end

	// Monitor: check each record transaction against the oldest prediction.
	always @(posedge clk) begin
		record_t got, want;
		if (rec_ch.valid && rec_ch.ready) begin
			got = '{rec_ch.record_kind, rec_ch.set_length, rec_ch.wide_offsets,
				rec_ch.format_version, rec_ch.info_offset, rec_ch.address_bytes,
				rec_ch.segment_bytes, rec_ch.range_start, rec_ch.range_length,
				rec_ch.last_of_set};
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record %h", got);
			end else begin
				want = expected_records.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("record mismatch: expected %h got %h", want, got);
				end
			end
		end
		rec_ch.ready <= (cycle inside {[400:1000]}) || $urandom_range(0, 99) >= 8;
	end

	// Watchdog: drop the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (rec_ch.valid && rec_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int stop_kind;
		logic [7:0] bad_asz;
		byte_ch.valid = 1'b0;
		byte_ch.section_byte = '0;
		rec_ch.ready = 1'b0;
		sec_size = '0;
		sec_big = 1'b0;
		ph = P_LEN32;
		sec_pos = '0;
		unit_left = '0;
		acc = '0;
		acc_cnt = '0;
		unit_wide = 1'b0;
		hold_version = '0;
		hold_offset = '0;
		hold_asize = '0;
		hold_ssize = '0;
		pairs_left = '0;
		hold_start = '0;
		halted = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Empty section out of reset: these bytes are ignored.
		repeat (3) pending_bytes.push_back(8'($urandom));
		wait_idle();

		// Directed: narrowest and widest addresses, 64-bit unit, field
		// extremes, zero-pair end with skipped remainder, count run-out.
		build_big = 1'b0;
		add_unit(1'b0, 1, 2, 2, 1'b0, 0, 16'h0000, 64'h0);
		add_unit(1'b1, 8, 2, 1, 1'b1, 7, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_unit(1'b0, 4, 1, 1, 1'b1, 0, 16'h0002, 64'hFFFF_FFFF);
		send_section(1'b0, 1'b0, 2);
		build_big = 1'b1;
		add_unit(1'b0, 8, 1, 1, 1'b0, 3, 16'h8001, 64'h1234_5678);
		add_unit(1'b1, 2, 3, 2, 1'b1, 1, 16'h0003, 64'h8000_0000_0000_0001);
		send_section(1'b1, 1'b0, 0);

		// Random sections, each in a random byte order, one at the largest size.
		for (int p = 0; sent < TARGET_BYTES; p++) begin
			build_big = $urandom_range(0, 1);
			repeat ($urandom_range(3, 6)) add_random_unit();
			send_section(build_big, p == 2, $urandom_range(0, 3));
		end

		// Close on one malformed unit; everything after the stop is ignored.
		build_big = $urandom_range(0, 1);
		stop_kind = $urandom_range(0, 4);
		write_reg(CFG_BYTE_ORDER, 32'(build_big));
		case (stop_kind)
			0: add_field(64'($urandom_range(0, 7)), 4);
			1: add_field(64'hFFFF_FFF0, 4);
			2, 3: begin
				add_field(64'd12, 4);
				add_field(64'($urandom), 2);
				add_field(64'($urandom), 4);
				if (stop_kind == 2) begin
					do bad_asz = 8'($urandom);
					while (bad_asz inside {8'd1, 8'd2, 8'd4, 8'd8});
					unit_bytes.push_back(bad_asz);
				end else begin
					unit_bytes.push_back(8'd8);
				end
				unit_bytes.push_back(8'($urandom));
			end
			default: repeat (2) unit_bytes.push_back(8'($urandom));
		endcase
		write_reg(CFG_SECTION_BYTES, stop_kind == 4 ? sec_pos + 32'd2 : 32'hFFFF_FFFF);
		while (unit_bytes.size() != 0)
			pending_bytes.push_back(unit_bytes.pop_front());
		repeat (8) pending_bytes.push_back(8'($urandom));

		while (pending_bytes.size() != 0 || expected_records.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/daratp_pkg.sv
hdl/daratp_byte_if.sv
hdl/daratp_record_if.sv
hdl/daratp_out_buf.sv
hdl/dwarf_address_range_table_parser.sv
tb/tb_dwarf_address_range_table_parser.sv
